// ----- rtl/core/scsi_disk_target_engine_unit_defines.svh -----
// Assertion macros used by the port checker of the disk target engine.
`ifndef SCSI_DISK_TARGET_ENGINE_UNIT_DEFINES_SVH
`define SCSI_DISK_TARGET_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SDTE_ASSERT_IMPLY(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("sdte check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define SDTE_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("sdte check failed");

`endif

// ----- rtl/core/sdte_pkg.sv -----
// Types, codes and constant tables of the disk target engine.
package sdte_pkg;

  localparam int SECTOR_BYTES = 512;
  localparam int SEC_AW = $clog2(SECTOR_BYTES);
  localparam int SEC_PW = SEC_AW + 1;
  localparam logic [31:0] LBA_RESET = 32'd528807;
  localparam logic [15:0] INQ_LEN = 16'd96;
  localparam logic [15:0] CAP_LEN = 16'd8;
  localparam logic [31:0] SECTOR_BYTES_W = 32'(SECTOR_BYTES);

  localparam logic [7:0] OP_TUR      = 8'h00;
  localparam logic [7:0] OP_PREVENT  = 8'h1e;
  localparam logic [7:0] OP_INQUIRY  = 8'h12;
  localparam logic [7:0] OP_MSENSE   = 8'h1a;
  localparam logic [7:0] OP_RDCAP    = 8'h25;
  localparam logic [7:0] OP_READ6    = 8'h08;
  localparam logic [7:0] OP_READ10   = 8'h28;
  localparam logic [7:0] OP_WRITE6   = 8'h0a;
  localparam logic [7:0] OP_WRITE10  = 8'h2a;

  localparam logic [5:0] PAGE_GEOM  = 6'h03;
  localparam logic [5:0] PAGE_RIGID = 6'h04;
  localparam logic [5:0] PAGE_ALL   = 6'h3f;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_INQ  = 3'd1,
    PH_MODE = 3'd2,
    PH_CAP  = 3'd3,
    PH_FILL = 3'd4,
    PH_SEND = 3'd5,
    PH_RECV = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    IK_CMD  = 2'd0,
    IK_PULL = 2'd1,
    IK_DATA = 2'd2,
    IK_FILL = 2'd3
  } item_kind_t;

  typedef enum logic [2:0] {
    RK_DATA     = 3'd0,
    RK_DONE     = 3'd1,
    RK_RDREQ    = 3'd2,
    RK_WRBYTE   = 3'd3,
    RK_NOTREADY = 3'd4,
    RK_UNSUP    = 3'd5
  } res_kind_t;

  localparam logic [7:0] INQ_HEAD [32] = '{
    8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h02,
    8'h41, 8'h72, 8'h63, 8'h75, 8'h6c, 8'h61, 8'h74, 8'h72,
    8'h41, 8'h72, 8'h63, 8'h75, 8'h6c, 8'h61, 8'h74, 8'h6f,
    8'h72, 8'h53, 8'h43, 8'h53, 8'h49, 8'h48, 8'h44, 8'h20
  };

  localparam logic [7:0] GEOM_PAGE [24] = '{
    8'h03, 8'h16, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h01,
    8'h00, 8'h01, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] RIGID_PAGE [24] = '{
    8'h04, 8'h16, 8'h00, 8'h10, 8'h00, 8'h40, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00
  };

  // Byte lane of a big-endian 32-bit word.
  function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] i);
    logic [7:0] b;
    case (i)
      2'd0: b = w[31:24];
      2'd1: b = w[23:16];
      2'd2: b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/core/scsi_disk_target_engine_unit.sv -----
// Top level of the direct-access disk target engine.
// Direct-access disk target engine. Each input word is one event of the bus
// (a new command descriptor, an initiator pull, an initiator data byte or a
// storage fill byte); each result word is a data byte, a completion, a sector
// read request, a storage write byte, a not-ready or an unsupported answer.
// The engine takes one input word per clock while in_stall is low. A word that
// yields one result (or none) leaves the engine ready for the next word in the
// following cycle unless the receiver stalls; a word that yields two results
// (last byte plus completion, or last byte of a sector plus the next sector
// request) holds the output register until both results are taken. The sector
// buffer is a 512 x 8 memory with one write and one registered read port: fill
// and receive bytes write it, pulls during a read transfer read it, and the
// read data is registered as the word enters the output register and joins it.
// A whole sector is filled before any byte of it is read, so the two ports
// never meet on one entry. The buffer needs no clearing pass after reset. Write
// last_block_address through cfg_write/cfg_data only while the engine idles.
module scsi_disk_target_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  item_kind,
  input  logic [7:0]  cmd_byte0,
  input  logic [7:0]  cmd_byte1,
  input  logic [7:0]  cmd_byte2,
  input  logic [7:0]  cmd_byte3,
  input  logic [7:0]  cmd_byte4,
  input  logic [7:0]  cmd_byte5,
  input  logic [7:0]  cmd_byte7,
  input  logic [7:0]  cmd_byte8,
  input  logic [7:0]  data_value,
  input  logic        stop_flag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  result_kind,
  output logic [7:0]  out_byte,
  output logic [31:0] block_number,
  output logic [8:0]  byte_offset,
  output logic        final_mark
);
  import sdte_pkg::*;

  // Control state.
  logic [31:0]       last_block_address;
  phase_t            phase, phase_next;
  logic [31:0]       current_block, current_block_next;
  logic [16:0]       sectors_left, sectors_left_next;
  logic [SEC_PW-1:0] sector_position, sector_position_next;
  logic [SEC_PW-1:0] fill_count, fill_count_next;
  logic [15:0]       reply_index, reply_index_next;
  logic [15:0]       reply_limit, reply_limit_next;
  logic [5:0]        page_select, page_select_next;

  // Sector buffer.
  logic [7:0]        sector_store [SECTOR_BYTES];
  logic              mem_we, mem_re;
  logic [SEC_AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;

  // Output register: up to two results of one word.
  logic        s_valid, s_sel, s_has1, s_mem;
  res_kind_t   s_k0, s_k1;
  logic [7:0]  s_b0;
  logic [31:0] s_blk0, s_blk1;
  logic [8:0]  s_off0;
  logic        s_fin0;

  // Results of the word at the input.
  logic        has0, has1, r0_mem, r0_fin;
  res_kind_t   r0_k, r1_k;
  logic [7:0]  r0_b;
  logic [31:0] r0_blk, r1_blk;
  logic [8:0]  r0_off;

  logic in_acc, out_acc, out_last;

  // Descriptor decode.
  logic [31:0] a6, a10;
  logic [16:0] c6, c10;
  logic [15:0] inq_len;
  logic [7:0]  reply_b;
  logic [15:0] mj, mk;
  logic        p3, p4;
  logic [SEC_PW-1:0] pos_inc;

  assign out_last = s_sel || !s_has1;
  assign out_acc  = out_valid && !out_stall;
  // Take a new word unless the output register holds results not all taken now.
  assign in_stall = s_valid && !(out_acc && out_last);
  assign in_acc   = in_valid && !in_stall;

  assign a6  = {11'd0, cmd_byte1[4:0], cmd_byte2, cmd_byte3};
  assign a10 = {cmd_byte2, cmd_byte3, cmd_byte4, cmd_byte5};
  assign c6  = (cmd_byte4 == 8'd0) ? 17'd256 : {9'd0, cmd_byte4};
  assign c10 = {1'b0, cmd_byte7, cmd_byte8};
  assign inq_len = ({cmd_byte3, cmd_byte4} < INQ_LEN) ? {cmd_byte3, cmd_byte4} : INQ_LEN;
  assign pos_inc = sector_position + SEC_PW'(1);

  // Reply byte of the current reply phase at reply_index.
  always_comb begin
    p3 = (page_select == PAGE_GEOM) || (page_select == PAGE_ALL);
    p4 = (page_select == PAGE_RIGID) || (page_select == PAGE_ALL);
    mj = reply_index - 16'd4;
    mk = p3 ? (mj - 16'd24) : mj;
    reply_b = 8'd0;
    case (phase)
      PH_INQ: begin
        if (reply_index < 16'd32) reply_b = INQ_HEAD[reply_index[4:0]];
      end
      PH_CAP: begin
        if (reply_index < 16'd4) begin
          reply_b = be_byte(last_block_address, reply_index[1:0]);
        end else if (reply_index < 16'd8) begin
          reply_b = be_byte(SECTOR_BYTES_W, reply_index[1:0]);
        end
      end
      default: begin
        // Mode sense: header, then the selected pages, then zero pad.
        if (reply_index < 16'd4) begin
          reply_b = (reply_index == 16'd0) ? 8'(reply_limit - 16'd4) : 8'd0;
        end else if (p3 && mj < 16'd24) begin
          reply_b = GEOM_PAGE[mj[4:0]];
        end else if (p4 && mk < 16'd24) begin
          reply_b = RIGID_PAGE[mk[4:0]];
        end
      end
    endcase
  end

  // Next state and results of one word.
  always_comb begin
    phase_next           = phase;
    current_block_next   = current_block;
    sectors_left_next    = sectors_left;
    sector_position_next = sector_position;
    fill_count_next      = fill_count;
    reply_index_next     = reply_index;
    reply_limit_next     = reply_limit;
    page_select_next     = page_select;
    has0 = 1'b0;  has1 = 1'b0;
    r0_k = RK_DONE;  r0_b = 8'd0;  r0_blk = 32'd0;  r0_off = 9'd0;
    r0_fin = 1'b0;  r0_mem = 1'b0;
    r1_k = RK_DONE;  r1_blk = 32'd0;
    mem_we = 1'b0;  mem_waddr = fill_count[SEC_AW-1:0];  mem_wdata = data_value;
    mem_re = 1'b0;  mem_raddr = sector_position[SEC_AW-1:0];

    case (item_kind_t'(item_kind))
      IK_CMD: begin
        case (cmd_byte0)
          OP_TUR, OP_PREVENT: begin
            phase_next = PH_IDLE;
            has0 = 1'b1;  r0_k = RK_DONE;  r0_fin = 1'b1;
          end
          OP_INQUIRY, OP_MSENSE, OP_RDCAP: begin
            reply_index_next = 16'd0;
            if (cmd_byte0 == OP_INQUIRY) begin
              reply_limit_next = inq_len;
              phase_next = PH_INQ;
            end else if (cmd_byte0 == OP_MSENSE) begin
              reply_limit_next = {8'd0, cmd_byte4};
              page_select_next = cmd_byte2[5:0];
              phase_next = PH_MODE;
            end else begin
              reply_limit_next = CAP_LEN;
              phase_next = PH_CAP;
            end
            // Zero length: complete at once.
            if (reply_limit_next == 16'd0) begin
              phase_next = PH_IDLE;
              has0 = 1'b1;  r0_k = RK_DONE;  r0_fin = 1'b1;
            end
          end
          OP_READ6, OP_READ10, OP_WRITE6, OP_WRITE10: begin
            if (cmd_byte0 == OP_READ6 || cmd_byte0 == OP_WRITE6) begin
              current_block_next = a6;
              sectors_left_next  = c6;
            end else begin
              current_block_next = a10;
              sectors_left_next  = c10;
            end
            sector_position_next = '0;
            fill_count_next      = '0;
            if (sectors_left_next == 17'd0) begin
              phase_next = PH_IDLE;
              has0 = 1'b1;  r0_k = RK_DONE;  r0_fin = 1'b1;
            end else if (cmd_byte0 == OP_READ6 || cmd_byte0 == OP_READ10) begin
              phase_next = PH_FILL;
              has0 = 1'b1;  r0_k = RK_RDREQ;  r0_blk = current_block_next;
            end else begin
              phase_next = PH_RECV;
            end
          end
          default: begin
            phase_next = PH_IDLE;
            has0 = 1'b1;  r0_k = RK_UNSUP;  r0_fin = 1'b1;
          end
        endcase
      end
      IK_PULL: begin
        has0 = 1'b1;
        if (phase == PH_INQ || phase == PH_MODE || phase == PH_CAP) begin
          r0_k = RK_DATA;  r0_b = reply_b;
          reply_index_next = reply_index + 16'd1;
          if (reply_index_next >= reply_limit) begin
            phase_next = PH_IDLE;
            has1 = 1'b1;  r1_k = RK_DONE;
          end
        end else if (phase == PH_SEND) begin
          r0_k = RK_DATA;  r0_mem = 1'b1;  mem_re = 1'b1;
          sector_position_next = pos_inc;
          if (stop_flag) begin
            phase_next = PH_IDLE;
            has1 = 1'b1;  r1_k = RK_DONE;
          end else if (pos_inc == SEC_PW'(SECTOR_BYTES)) begin
            sector_position_next = '0;
            current_block_next   = current_block + 32'd1;
            sectors_left_next    = sectors_left - 17'd1;
            has1 = 1'b1;
            if (sectors_left_next == 17'd0) begin
              phase_next = PH_IDLE;
              r1_k = RK_DONE;
            end else begin
              phase_next = PH_FILL;
              fill_count_next = '0;
              r1_k = RK_RDREQ;  r1_blk = current_block_next;
            end
          end
        end else begin
          r0_k = RK_NOTREADY;
        end
      end
      IK_DATA: begin
        has0 = 1'b1;
        if (phase == PH_RECV) begin
          mem_we = 1'b1;  mem_waddr = sector_position[SEC_AW-1:0];
          r0_k = RK_WRBYTE;  r0_b = data_value;  r0_blk = current_block;
          r0_off = 9'(sector_position);
          sector_position_next = pos_inc;
          if (stop_flag) begin
            phase_next = PH_IDLE;
            has1 = 1'b1;  r1_k = RK_DONE;
          end else if (pos_inc == SEC_PW'(SECTOR_BYTES)) begin
            sector_position_next = '0;
            current_block_next   = current_block + 32'd1;
            sectors_left_next    = sectors_left - 17'd1;
            if (sectors_left_next == 17'd0) begin
              phase_next = PH_IDLE;
              has1 = 1'b1;  r1_k = RK_DONE;
            end
          end
        end else begin
          r0_k = RK_NOTREADY;
        end
      end
      default: begin
        // Fill byte: store it, switch to sending once the sector is full.
        if (phase == PH_FILL) begin
          mem_we = 1'b1;
          fill_count_next = fill_count + SEC_PW'(1);
          if (fill_count_next == SEC_PW'(SECTOR_BYTES)) begin
            phase_next = PH_SEND;
            sector_position_next = '0;
          end
        end
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_block_address <= LBA_RESET;
      phase           <= PH_IDLE;
      current_block   <= '0;
      sectors_left    <= '0;
      sector_position <= '0;
      fill_count      <= '0;
      reply_index     <= '0;
      reply_limit     <= '0;
      page_select     <= '0;
    end else begin
      if (cfg_write) last_block_address <= cfg_data;
      if (in_acc) begin
        phase           <= phase_next;
        current_block   <= current_block_next;
        sectors_left    <= sectors_left_next;
        sector_position <= sector_position_next;
        fill_count      <= fill_count_next;
        reply_index     <= reply_index_next;
        reply_limit     <= reply_limit_next;
        page_select     <= page_select_next;
      end
    end
  end

  // Sector buffer: one write port, one registered read port; read data
  // holds until the next pull so a stalled output keeps its byte.
  always_ff @(posedge clk) begin
    if (in_acc && mem_we) sector_store[mem_waddr] <= mem_wdata;
    if (in_acc && mem_re) mem_rdata <= sector_store[mem_raddr];
  end

  // Output register: load a new word, or step from the first to the second
  // result, or drop the entry once its last result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      s_sel   <= 1'b0;
    end else if (in_acc) begin
      s_valid <= has0;
      s_sel   <= 1'b0;
    end else if (out_acc) begin
      if (out_last) s_valid <= 1'b0;
      else          s_sel   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_has1 <= has1;
      s_mem  <= r0_mem;
      s_k0   <= r0_k;
      s_b0   <= r0_b;
      s_blk0 <= r0_blk;
      s_off0 <= r0_off;
      s_fin0 <= r0_fin;
      s_k1   <= r1_k;
      s_blk1 <= r1_blk;
    end
  end

  assign out_valid    = s_valid;
  assign result_kind  = s_sel ? s_k1 : s_k0;
  assign out_byte     = s_sel ? 8'd0 : (s_mem ? mem_rdata : s_b0);
  assign block_number = s_sel ? s_blk1 : s_blk0;
  assign byte_offset  = s_sel ? 9'd0 : s_off0;
  assign final_mark   = s_sel ? (s_k1 == RK_DONE) : s_fin0;

endmodule

// ----- rtl/core/sdte_checker.sv -----
// Port-level checker of the disk target engine and its bind.
module sdte_port_assert (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  result_kind,
  input logic [7:0]  out_byte,
  input logic [31:0] block_number,
  input logic [8:0]  byte_offset,
  input logic        final_mark
);
`include "scsi_disk_target_engine_unit_defines.svh"
  import sdte_pkg::*;

  // A stalled result word holds.
  `SDTE_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(result_kind) && $stable(block_number))
  // Final mark only on completion or unsupported.
  `SDTE_ASSERT_IMPLY(a_final, out_valid, final_mark == (result_kind == RK_DONE || result_kind == RK_UNSUP))
  // Offset only on storage write bytes.
  `SDTE_ASSERT_IMPLY(a_offset, out_valid && result_kind != RK_WRBYTE, byte_offset == 9'd0)
  // Byte only on data and storage write bytes.
  `SDTE_ASSERT_IMPLY(a_byte, out_valid && result_kind != RK_DATA && result_kind != RK_WRBYTE, out_byte == 8'd0)

endmodule

bind scsi_disk_target_engine_unit sdte_port_assert u_sdte_port_assert (.*);

// ----- tb/sdte_checker.sv -----
// Scoreboard of the disk target engine: watches both channels, predicts results and compares them.
`timescale 1ns / 1ps

module sdte_checker
  import sdte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  item_kind,
  input  logic [7:0]  cmd_byte0,
  input  logic [7:0]  cmd_byte1,
  input  logic [7:0]  cmd_byte2,
  input  logic [7:0]  cmd_byte3,
  input  logic [7:0]  cmd_byte4,
  input  logic [7:0]  cmd_byte5,
  input  logic [7:0]  cmd_byte7,
  input  logic [7:0]  cmd_byte8,
  input  logic [7:0]  data_value,
  input  logic        stop_flag,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  result_kind,
  input  logic [7:0]  out_byte,
  input  logic [31:0] block_number,
  input  logic [8:0]  byte_offset,
  input  logic        final_mark,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    res_kind_t   kind;
    logic [7:0]  data;
    logic [31:0] blk;
    logic [8:0]  off;
    logic        fin;
  } answer_t;

  answer_t     answers_due[$];

  logic [31:0] last_lba;
  phase_t      ph;
  logic [31:0] cur_blk;
  logic [16:0] secs_left;
  logic [9:0]  sec_pos;
  logic [7:0]  buffer [SECTOR_BYTES];
  logic [9:0]  fill_cnt;
  logic [15:0] rep_idx;
  logic [15:0] rep_len;
  logic [5:0]  page;

  initial begin
    errors = 0;
    pending = 0;
  end

  task automatic post(input res_kind_t k, input logic [7:0] d, input logic [31:0] b,
                      input logic [8:0] o, input logic f);
    answer_t a;
    a.kind = k;
    a.data = d;
    a.blk  = b;
    a.off  = o;
    a.fin  = f;
    answers_due.push_back(a);
  endtask

  task automatic flag_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    errors++;
  endtask

  function automatic logic [7:0] reply_at();
    int j;
    j = int'(rep_idx);
    if (ph == PH_INQ) return (j < 32) ? INQ_HEAD[j] : 8'h00;
    if (ph == PH_CAP) begin
      if (j < 4) return last_lba[8*(3-j) +: 8];
      if (j < 8) return SECTOR_BYTES_W[8*(7-j) +: 8];
      return 8'h00;
    end
    // mode sense: header, then the selected pages, then zero padding
    if (j < 4) return (j == 0) ? 8'(rep_len - 16'd4) : 8'h00;
    j -= 4;
    if (page == PAGE_GEOM || page == PAGE_ALL) begin
      if (j < 24) return GEOM_PAGE[j];
      j -= 24;
    end
    if ((page == PAGE_RIGID || page == PAGE_ALL) && j < 24) return RIGID_PAGE[j];
    return 8'h00;
  endfunction

  task automatic begin_reply(input phase_t p, input logic [15:0] n);
    rep_idx = '0;
    rep_len = n;
    if (n == 16'd0) begin
      ph = PH_IDLE;
      post(RK_DONE, 0, 0, 0, 1'b1);
    end else begin
      ph = p;
    end
  endtask

  task automatic begin_move(input logic rd, input logic [31:0] b, input logic [16:0] n);
    secs_left = n;
    cur_blk = b;
    sec_pos = '0;
    fill_cnt = '0;
    if (n == 0) begin
      ph = PH_IDLE;
      post(RK_DONE, 0, 0, 0, 1'b1);
    end else if (rd) begin
      ph = PH_FILL;
      post(RK_RDREQ, 0, cur_blk, 0, 1'b0);
    end else begin
      ph = PH_RECV;
    end
  endtask

  // Advance to the next sector; end the transfer after the last one.
  task automatic sector_done(input logic rd);
    sec_pos = '0;
    cur_blk = cur_blk + 32'd1;
    secs_left = secs_left - 17'd1;
    if (secs_left == 0) begin
      ph = PH_IDLE;
      post(RK_DONE, 0, 0, 0, 1'b1);
    end else if (rd) begin
      ph = PH_FILL;
      fill_cnt = '0;
      post(RK_RDREQ, 0, cur_blk, 0, 1'b0);
    end
  endtask

  task automatic take_word();
    logic [16:0] c6;
    logic [15:0] inq_n;
    c6 = (cmd_byte4 == 0) ? 17'd256 : 17'(cmd_byte4);
    inq_n = {cmd_byte3, cmd_byte4};
    case (item_kind_t'(item_kind))
      IK_CMD: begin
        case (cmd_byte0)
          OP_TUR, OP_PREVENT: begin
            ph = PH_IDLE;
            post(RK_DONE, 0, 0, 0, 1'b1);
          end
          OP_INQUIRY: begin_reply(PH_INQ, (inq_n < INQ_LEN) ? inq_n : INQ_LEN);
          OP_MSENSE: begin
            page = cmd_byte2[5:0];
            begin_reply(PH_MODE, 16'(cmd_byte4));
          end
          OP_RDCAP:   begin_reply(PH_CAP, CAP_LEN);
          OP_READ6:   begin_move(1'b1, {11'd0, cmd_byte1[4:0], cmd_byte2, cmd_byte3}, c6);
          OP_WRITE6:  begin_move(1'b0, {11'd0, cmd_byte1[4:0], cmd_byte2, cmd_byte3}, c6);
          OP_READ10:  begin_move(1'b1, {cmd_byte2, cmd_byte3, cmd_byte4, cmd_byte5},
                                 {1'b0, cmd_byte7, cmd_byte8});
          OP_WRITE10: begin_move(1'b0, {cmd_byte2, cmd_byte3, cmd_byte4, cmd_byte5},
                                 {1'b0, cmd_byte7, cmd_byte8});
          default: begin
            ph = PH_IDLE;
            post(RK_UNSUP, 0, 0, 0, 1'b1);
          end
        endcase
      end
      IK_PULL: begin
        if (ph == PH_INQ || ph == PH_MODE || ph == PH_CAP) begin
          post(RK_DATA, reply_at(), 0, 0, 1'b0);
          rep_idx = rep_idx + 16'd1;
          if (rep_idx >= rep_len) begin
            ph = PH_IDLE;
            post(RK_DONE, 0, 0, 0, 1'b1);
          end
        end else if (ph == PH_SEND && sec_pos < SECTOR_BYTES) begin
          post(RK_DATA, buffer[sec_pos[8:0]], 0, 0, 1'b0);
          sec_pos = sec_pos + 10'd1;
          if (stop_flag) begin
            ph = PH_IDLE;
            post(RK_DONE, 0, 0, 0, 1'b1);
          end else if (sec_pos >= SECTOR_BYTES) begin
            sector_done(1'b1);
          end
        end else begin
          post(RK_NOTREADY, 0, 0, 0, 1'b0);
        end
      end
      IK_DATA: begin
        if (ph == PH_RECV && sec_pos < SECTOR_BYTES) begin
          buffer[sec_pos[8:0]] = data_value;
          post(RK_WRBYTE, data_value, cur_blk, sec_pos[8:0], 1'b0);
          sec_pos = sec_pos + 10'd1;
          if (stop_flag) begin
            ph = PH_IDLE;
            post(RK_DONE, 0, 0, 0, 1'b1);
          end else if (sec_pos >= SECTOR_BYTES) begin
            sector_done(1'b0);
          end
        end else begin
          post(RK_NOTREADY, 0, 0, 0, 1'b0);
        end
      end
      default: begin
        // fill words outside a fill are dropped without an answer
        if (ph == PH_FILL && fill_cnt < SECTOR_BYTES) begin
          buffer[fill_cnt[8:0]] = data_value;
          fill_cnt = fill_cnt + 10'd1;
          if (fill_cnt >= SECTOR_BYTES) begin
            ph = PH_SEND;
            sec_pos = '0;
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    answer_t e;
    if (rst) begin
      last_lba = LBA_RESET;
      ph = PH_IDLE;
      cur_blk = '0;
      secs_left = '0;
      sec_pos = '0;
      fill_cnt = '0;
      rep_idx = '0;
      rep_len = '0;
      page = '0;
      answers_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected result kind %0d", result_kind));
        end else begin
          e = answers_due.pop_front();
          if (result_kind !== e.kind || out_byte !== e.data || block_number !== e.blk ||
              byte_offset !== e.off || final_mark !== e.fin)
            flag_mismatch($sformatf(
              "got k%0d b%02h blk%08h off%0d f%0d, want k%0d b%02h blk%08h off%0d f%0d",
              result_kind, out_byte, block_number, byte_offset, final_mark,
              e.kind, e.data, e.blk, e.off, e.fin));
        end
      end
      if (cfg_write) last_lba = cfg_data;
      if (in_valid && !in_stall) take_word();
    end
    pending = answers_due.size();
  end

endmodule

// ----- tb/tb.sv -----
// Stimulus and verdict for the disk target engine, with the scoreboard beside it.
`timescale 1ns / 1ps

module tb;
  import sdte_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_GOAL   = 1350;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  item_kind;
  logic [7:0]  cmd_byte0, cmd_byte1, cmd_byte2, cmd_byte3;
  logic [7:0]  cmd_byte4, cmd_byte5, cmd_byte7, cmd_byte8;
  logic [7:0]  data_value;
  logic        stop_flag;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  result_kind;
  logic [7:0]  out_byte;
  logic [31:0] block_number;
  logic [8:0]  byte_offset;
  logic        final_mark;

  int          errors;
  int          pending;
  int          words_sent;
  int          quiet_cycles;
  bit          quiet;
  bit          hold_req;

  scsi_disk_target_engine_unit uut (.*);

  sdte_checker scoreboard (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: end the run once no word moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: stall in random bursts, hold off once for a long stretch on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_stall = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one word and hold it until the engine takes it.
  task automatic push_word(input item_kind_t k, input logic [7:0] c0, c1, c2, c3, c4, c5,
                           c7, c8, d, input logic s);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    item_kind = k;
    cmd_byte0 = c0; cmd_byte1 = c1; cmd_byte2 = c2; cmd_byte3 = c3;
    cmd_byte4 = c4; cmd_byte5 = c5; cmd_byte7 = c7; cmd_byte8 = c8;
    data_value = d;
    stop_flag = s;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic send_cmd(input logic [7:0] op, b1, b2, b3, b4, b5, b7, b8);
    push_word(IK_CMD, op, b1, b2, b3, b4, b5, b7, b8, rnd8(), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_pull(input logic s);
    push_word(IK_PULL, rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), rnd8(),
              rnd8(), s);
  endtask

  task automatic send_data(input logic [7:0] d, input logic s);
    push_word(IK_DATA, rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), d, s);
  endtask

  task automatic send_fill(input logic [7:0] d);
    push_word(IK_FILL, rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), rnd8(),
              d, 1'($urandom_range(0, 1)));
  endtask

  // Drain: drop valid, wait for every expected result, then let trailing fills settle.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_lba(input logic [31:0] v);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Pull a reply; mostly the whole length, sometimes short or with extra pulls.
  task automatic pull_reply(input int n);
    int cnt;
    case ($urandom_range(0, 5))
      0:       cnt = $urandom_range(0, n);
      1:       cnt = n + $urandom_range(1, 2);
      default: cnt = n;
    endcase
    for (int i = 0; i < cnt; i++) send_pull(1'($urandom_range(0, 1)));
  endtask

  // One random command sequence; well formed most of the time.
  task automatic run_sequence();
    int          pick;
    int          n;
    int          secs;
    logic [15:0] len;
    logic [7:0]  pg;
    logic        ten;
    logic        ends_stopped;
    pick = $urandom_range(0, 99);
    ten = 1'($urandom_range(0, 1));
    if (pick < 6) begin
      send_cmd(($urandom_range(0, 1) != 0) ? OP_TUR : OP_PREVENT, rnd8(), rnd8(), rnd8(),
               rnd8(), rnd8(), rnd8(), rnd8());
    end else if (pick < 14) begin
      // noise: arbitrary words, opcodes included
      repeat ($urandom_range(1, 4))
        push_word(item_kind_t'($urandom_range(0, 3)), rnd8(), rnd8(), rnd8(), rnd8(), rnd8(),
                  rnd8(), rnd8(), rnd8(), rnd8(), 1'($urandom_range(0, 1)));
    end else if (pick < 24) begin
      len = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 120));
      send_cmd(OP_INQUIRY, rnd8(), rnd8(), len[15:8], len[7:0], rnd8(), rnd8(), rnd8());
      pull_reply((len < INQ_LEN) ? int'(len) : int'(INQ_LEN));
    end else if (pick < 40) begin
      case ($urandom_range(0, 4))
        0:       pg = {rnd8() & 8'hc0} | 8'(PAGE_GEOM);
        1:       pg = {rnd8() & 8'hc0} | 8'(PAGE_RIGID);
        2:       pg = {rnd8() & 8'hc0} | 8'(PAGE_ALL);
        3:       pg = rnd8() & 8'hc0;
        default: pg = rnd8();
      endcase
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 60);
      send_cmd(OP_MSENSE, rnd8(), pg, rnd8(), 8'(n), rnd8(), rnd8(), rnd8());
      pull_reply(n);
    end else if (pick < 48) begin
      send_cmd(OP_RDCAP, rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), rnd8());
      pull_reply(8);
    end else if (pick < 64) begin
      // write: mostly a short burst ended by stop, sometimes across a sector
      secs = $urandom_range(1, 3);
      if ($urandom_range(0, 9) == 0) secs = 0;
      if (ten)
        send_cmd(OP_WRITE10, rnd8(), rnd8(), rnd8(), rnd8(), rnd8(),
                 ($urandom_range(0, 9) == 0) ? rnd8() : 8'd0, 8'(secs));
      else
        send_cmd(OP_WRITE6, rnd8(), rnd8(), rnd8(), 8'(secs), rnd8(), rnd8(), rnd8());
      n = ($urandom_range(0, 7) == 0) ? SECTOR_BYTES + $urandom_range(0, 20)
                                      : $urandom_range(1, 40);
      ends_stopped = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < n; i++) send_data(rnd8(), ends_stopped && (i == n - 1));
    end else if (pick < 68) begin
      // read: fill a whole sector before pulling from it
      secs = $urandom_range(1, 2);
      if (ten)
        send_cmd(OP_READ10, rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), 8'd0, 8'(secs));
      else
        send_cmd(OP_READ6, rnd8(), rnd8(), rnd8(),
                 ($urandom_range(0, 3) == 0) ? 8'd0 : 8'(secs), rnd8(), rnd8(), rnd8());
      for (int i = 0; i < SECTOR_BYTES; i++) send_fill(rnd8());
      if ($urandom_range(0, 2) == 0) begin
        for (int i = 0; i < SECTOR_BYTES; i++) send_pull(1'b0);
      end else begin
        n = $urandom_range(1, 30);
        for (int i = 0; i < n; i++) send_pull(i == n - 1);
      end
      repeat ($urandom_range(0, 3)) send_fill(rnd8());
    end else begin
      // stray pulls, data and fills outside their phase
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 2))
          0:       send_pull(1'($urandom_range(0, 1)));
          1:       send_data(rnd8(), 1'($urandom_range(0, 1)));
          default: send_fill(rnd8());
        endcase
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    item_kind = '0;
    {cmd_byte0, cmd_byte1, cmd_byte2, cmd_byte3} = '0;
    {cmd_byte4, cmd_byte5, cmd_byte7, cmd_byte8} = '0;
    data_value = '0;
    stop_flag = 1'b0;
    quiet = 1'b0;
    hold_req = 1'b0;
    words_sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: every opcode class, zero lengths, out-of-phase words, abandoned write.
    send_cmd(OP_TUR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_PREVENT, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_cmd(8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_pull(1'b0);
    send_data(8'hff, 1'b1);
    send_fill(8'h00);
    send_cmd(OP_INQUIRY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_MSENSE, 8'h00, 8'(PAGE_ALL), 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_RDCAP, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    for (int i = 0; i < 9; i++) send_pull(1'b1);
    send_cmd(OP_WRITE10, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00);
    send_cmd(OP_READ10, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00);
    send_cmd(OP_WRITE6, 8'hff, 8'hff, 8'hff, 8'h02, 8'h00, 8'h00, 8'h00);
    send_data(8'h00, 1'b0);
    send_cmd(OP_WRITE10, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_data(8'h5a, 1'b1);
    drain();

    // Random phases, each under its own capacity setting; the last runs at full rate.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       write_lba(32'h0000_0000);
        1:       write_lba(32'hffff_ffff);
        2:       write_lba($urandom);
        default: write_lba(LBA_RESET);
      endcase
      if (p == 1) hold_req = 1'b1;
      if (p == 3) quiet = 1'b1;
      while (words_sent < ITEM_GOAL * (p + 1) / 4) run_sequence();
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
